FILE: rtl/bstm_pkg.sv
// Shared types and constants for the bitmask signature table matcher.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package bstm_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int SIG_BITS_DEF    = 64;
  localparam int QUEUE_DEPTH     = 2;

  localparam int MODE_W   = 3;
  localparam int IDX_W    = 6;
  localparam int BIT_W    = 6;
  localparam int QUERY_W  = 64;
  localparam int RIDX_W   = 7;
  localparam int STAT_W   = 2;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [MODE_W-1:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SET    = 3'd2,
    OP_CLR    = 3'd3,
    OP_GET    = 3'd4,
    OP_MATCH  = 3'd5,
    OP_CLEAR  = 3'd6,
    OP_BAD    = 3'd7
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   entry_index;
    logic [BIT_W-1:0]   bit_index;
    logic               bit_ok;
    logic               query_ok;
    logic [QUERY_W-1:0] query_mask;
  } cmd_t;

  typedef struct packed {
    logic [RIDX_W-1:0] result_index;
    logic              bit_value;
    logic              found;
    status_t           status;
    logic              last;
  } res_t;

endpackage

FILE: rtl/bitmask_signature_table_matcher_top.sv
// Bitmask signature table matcher: top level.
// Command items enter on in_*, result items leave on out_*.
// Depends on bstm_pkg, bstm_front and bstm_back.
//
// Each input item is one command, selected by in_tuser (add, remove,
// set/clear/get bit, match, clear all). Every command returns one result
// item, except match, which returns one per matching entry in index order
// (not-found result when none match); out_tlast marks a command's final
// result.
// A two-entry command queue separates the accepting front from the
// executing back, so in_tready stays high while the back is busy or the
// result register is stalled, until the queue fills.
// Add, clear all and unused codes give their result from the execute
// state; remove and the bit commands first read the signature memory and
// give it from the move or bit state, unless their index is out of range
// or the remove is trivial. A match reads one entry per cycle through the
// read port of the signature memory, pausing while a result waits on out_tready.
// When out_tready is low the held result stays put and the back waits.
// Reset (rst_n low, synchronous) empties the queue and sets the entry
// count to zero; the signature memory is not cleared.
`timescale 1ns / 1ps

module bitmask_signature_table_matcher_top
  import bstm_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int SIG_BITS    = SIG_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // entry_index[5:0], bit_index[11:6], query_mask[75:12], zero[79:76]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode[2:0]
  input  logic [MODE_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // result_index[6:0], bit_value[7], found[8], status[10:9], zero[15:11]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;
  res_t res;

  bstm_front #(
    .SIG_BITS (SIG_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .mode        (in_tuser),
    .entry_index (in_tdata[5:0]),
    .bit_index   (in_tdata[11:6]),
    .query_mask  (in_tdata[75:12]),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop)
  );

  bstm_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SIG_BITS    (SIG_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_res   (res),
    .out_ready (out_tready)
  );

  assign out_tdata = {5'b0, res.status, res.found, res.bit_value, res.result_index};
  assign out_tlast = res.last;

endmodule

FILE: rtl/bstm_front.sv
// Front end: accepts command items, classifies them and queues them.
// Depends on bstm_pkg.
`timescale 1ns / 1ps

module bstm_front
  import bstm_pkg::*;
#(
  parameter int SIG_BITS = SIG_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  mode,
  input  logic [IDX_W-1:0]   entry_index,
  input  logic [BIT_W-1:0]   bit_index,
  input  logic [QUERY_W-1:0] query_mask,
  output logic               q_valid,
  output cmd_t               q_cmd,
  input  logic               q_pop
);

  localparam int SB = ((SIG_BITS + 7) / 8) * 8;
  localparam logic [QUERY_W-1:0] QMASK =
    (SB >= QUERY_W) ? {QUERY_W{1'b1}} : ((QUERY_W'(1) << SB) - QUERY_W'(1));
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          buf_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic          push;
  cmd_t          cmd_in;

  always_comb begin
    cmd_in             = '0;
    cmd_in.op          = op_t'(mode);
    cmd_in.entry_index = entry_index;
    cmd_in.bit_index   = bit_index;
    cmd_in.bit_ok      = ({1'b0, bit_index} < 7'(SB));
    cmd_in.query_ok    = ((query_mask & ~QMASK) == '0);
    cmd_in.query_mask  = query_mask;
  end

  assign in_ready = (level_r != LW'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (level_r != '0);
  assign q_cmd    = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (!push && q_pop) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= cmd_in;
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(QUEUE_DEPTH))
    else $error("queue level above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> level_r != '0)
    else $error("pop from empty queue");

  a_level_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> level_r == $past(level_r) + 1'b1)
    else $error("queue level lost a push");

endmodule

FILE: rtl/bstm_back.sv
// Back end: executes queued commands against the signature memory and
// entry count, and holds the result item register. Depends on bstm_pkg.
`timescale 1ns / 1ps

module bstm_back
  import bstm_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int SIG_BITS    = SIG_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic out_valid,
  output res_t out_res,
  input  logic out_ready
);

  localparam int SB = ((SIG_BITS + 7) / 8) * 8;
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_MOVE = 6'b000100,
    S_BIT  = 6'b001000,
    S_SCAN = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  logic [SB-1:0] mem [MAX_ENTRIES];
  logic [SB-1:0] rd_data_r;

  state_t        state_r, state_nxt;
  cmd_t          cmd_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] scan_idx_r, scan_idx_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;
  logic          out_valid_r;
  res_t          out_res_r;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [SB-1:0] mem_wdata;
  logic          emit;
  res_t          emit_res;
  logic          out_free;

  logic          idx_oor, full, rm_trivial, hit, scan_end;
  logic [CW-1:0] count_dec;
  logic [SB-1:0] q_masked, bitsel, shifted;

  assign out_free   = !out_valid_r || out_ready;
  assign count_dec  = count_r - 1'b1;
  assign idx_oor    = XW'(cmd_r.entry_index) >= XW'(count_r);
  assign full       = (count_r == CW'(MAX_ENTRIES));
  assign rm_trivial = (count_dec == '0) || (XW'(count_dec) == XW'(cmd_r.entry_index));
  assign q_masked   = cmd_r.query_mask[SB-1:0];
  assign hit        = ((rd_data_r & q_masked) == q_masked);
  assign scan_end   = (scan_idx_r == AW'(count_dec));
  assign bitsel     = {{(SB-1){1'b0}}, 1'b1} << cmd_r.bit_index;
  assign shifted    = rd_data_r >> cmd_r.bit_index;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    q_pop          = 1'b0;
    emit           = 1'b0;
    emit_res       = '0;
    emit_res.last  = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd_r.op)
          OP_ADD: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (full) begin
                emit_res.status = ST_FULL;
              end else begin
                mem_we                = 1'b1;
                mem_waddr             = AW'(count_r);
                emit_res.result_index = RIDX_W'(count_r);
                count_nxt             = count_r + 1'b1;
              end
            end
          end
          OP_REMOVE: begin
            if (idx_oor || rm_trivial) begin
              if (out_free) begin
                emit      = 1'b1;
                state_nxt = S_IDLE;
                if (idx_oor) begin
                  emit_res.status = ST_RANGE;
                end else begin
                  count_nxt = count_dec;
                end
              end
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(count_dec);
              state_nxt = S_MOVE;
            end
          end
          OP_SET, OP_CLR, OP_GET: begin
            if (idx_oor) begin
              if (out_free) begin
                emit            = 1'b1;
                emit_res.status = ST_RANGE;
                state_nxt       = S_IDLE;
              end
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(cmd_r.entry_index);
              state_nxt = S_BIT;
            end
          end
          OP_MATCH: begin
            if (!cmd_r.query_ok || count_r == '0) begin
              if (out_free) begin
                emit      = 1'b1;
                state_nxt = S_IDLE;
              end
            end else begin
              mem_re         = 1'b1;
              mem_raddr      = '0;
              scan_idx_nxt   = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = S_SCAN;
            end
          end
          OP_CLEAR: begin
            if (out_free) begin
              emit      = 1'b1;
              count_nxt = '0;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              emit            = 1'b1;
              emit_res.status = ST_RANGE;
              state_nxt       = S_IDLE;
            end
          end
        endcase
      end
      S_MOVE: begin
        if (out_free) begin
          mem_we                = 1'b1;
          mem_waddr             = AW'(cmd_r.entry_index);
          mem_wdata             = rd_data_r;
          count_nxt             = count_dec;
          emit                  = 1'b1;
          emit_res.result_index = RIDX_W'(count_dec);
          state_nxt             = S_IDLE;
        end
      end
      S_BIT: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          mem_waddr = AW'(cmd_r.entry_index);
          if (cmd_r.op == OP_SET) begin
            mem_we    = cmd_r.bit_ok;
            mem_wdata = rd_data_r | bitsel;
          end else if (cmd_r.op == OP_CLR) begin
            mem_we    = cmd_r.bit_ok;
            mem_wdata = rd_data_r & ~bitsel;
          end else begin
            emit_res.bit_value = cmd_r.bit_ok & shifted[0];
          end
        end
      end
      S_SCAN: begin
        if (!(hit && pend_valid_r && !out_free)) begin
          if (hit) begin
            if (pend_valid_r) begin
              emit                  = 1'b1;
              emit_res.result_index = RIDX_W'(pend_idx_r);
              emit_res.found        = 1'b1;
              emit_res.last         = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = scan_idx_r;
          end
          if (scan_end) begin
            state_nxt = S_DONE;
          end else begin
            mem_re       = 1'b1;
            mem_raddr    = AW'(scan_idx_r + 1'b1);
            scan_idx_nxt = AW'(scan_idx_r + 1'b1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (pend_valid_r) begin
            emit_res.result_index = RIDX_W'(pend_idx_r);
            emit_res.found        = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (emit) begin
      out_res_r <= emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result register overwritten");

  a_scan_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> CW'(scan_idx_r) < count_r)
    else $error("scan beyond live entries");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_res.last) |=> state_r == S_IDLE)
    else $error("command continued after last result");

endmodule
